// File: rtl/lfr_pkg.sv
package lfr_pkg;

  localparam int FrameIdBits = 8;
  localparam int MaxEntriesDef = 16;
  localparam int CapBits = 5;
  localparam int OccBits = 5;
  localparam logic [CapBits-1:0] CapacityReset = 5'd16;

  typedef enum logic [1:0] {
    CmdSelect = 2'd0,
    CmdTouch  = 2'd1,
    CmdInsert = 2'd2,
    CmdRemove = 2'd3
  } lfr_cmd_e;

  typedef struct packed {
    lfr_cmd_e               command;
    logic [FrameIdBits-1:0] frame_no;
  } lfr_in_t;

  typedef struct packed {
    logic                   victim_valid;
    logic [FrameIdBits-1:0] victim_id;
    logic [OccBits-1:0]     occupancy;
  } lfr_out_t;

endpackage

// File: rtl/lfr_in_stage.sv
module lfr_in_stage import lfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  lfr_in_t in_data_i,
  input  logic    advance_i,
  output logic    valid_o,
  output lfr_in_t data_o
);

  logic    valid_q, valid_d;
  lfr_in_t data_q;
  logic    accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/lfr_list.sv
module lfr_list import lfr_pkg::*; #(
  parameter int MaxEntries = MaxEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  lfr_in_t            item_i,
  input  logic [CapBits-1:0] capacity_i,
  output lfr_out_t           res_o
);

  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int SlotW = $clog2(MaxEntries);
  localparam int ExtW = (CntW > CapBits) ? CntW : CapBits;

  logic [FrameIdBits-1:0] ids_q [MaxEntries];
  logic [FrameIdBits-1:0] ids_d [MaxEntries];
  logic [CntW-1:0]        count_q, count_d;

  logic [MaxEntries-1:0] hit;
  logic                  hit_any;
  logic [SlotW-1:0]      hit_idx;
  logic [ExtW-1:0]       eff_cap;
  logic                  full;
  logic                  drop;
  logic [SlotW-1:0]      drop_slot;
  logic                  write;
  logic [CntW-1:0]       wpos;
  logic                  victim_valid;
  logic [FrameIdBits-1:0] victim_id;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit[i] = (CntW'(i) < count_q) && (ids_q[i] == item_i.frame_no);
      if (hit[i]) begin
        hit_idx = hit_idx | SlotW'(i);
      end
    end
    hit_any = |hit;

    if (capacity_i == '0) begin
      eff_cap = ExtW'(1);
    end else if (ExtW'(capacity_i) > ExtW'(MaxEntries)) begin
      eff_cap = ExtW'(MaxEntries);
    end else begin
      eff_cap = ExtW'(capacity_i);
    end
    full = ExtW'(count_q) >= eff_cap;

    drop         = 1'b0;
    drop_slot    = '0;
    write        = 1'b0;
    victim_valid = 1'b0;
    victim_id    = '0;
    case (item_i.command)
      CmdSelect: begin
        if (count_q != '0) begin
          drop         = 1'b1;
          victim_valid = 1'b1;
          victim_id    = ids_q[0];
        end
      end
      CmdTouch: begin
        drop      = hit_any;
        drop_slot = hit_idx;
        write     = hit_any;
      end
      CmdInsert: begin
        if (hit_any) begin
          drop      = 1'b1;
          drop_slot = hit_idx;
        end else begin
          drop = full;
        end
        write = 1'b1;
      end
      CmdRemove: begin
        drop      = hit_any;
        drop_slot = hit_idx;
      end
      default: begin
        drop = 1'b0;
      end
    endcase

    wpos    = count_q - CntW'(drop);
    count_d = wpos + CntW'(write);

    for (int i = 0; i < MaxEntries; i++) begin
      int nxt;
      nxt = (i == MaxEntries - 1) ? i : i + 1;
      if (write && (CntW'(i) == wpos)) begin
        ids_d[i] = item_i.frame_no;
      end else if (drop && (SlotW'(i) >= drop_slot)) begin
        ids_d[i] = ids_q[nxt];
      end else begin
        ids_d[i] = ids_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ids_q <= ids_d;
    end
  end

  assign res_o.victim_valid = victim_valid;
  assign res_o.victim_id    = victim_id;
  assign res_o.occupancy    = OccBits'(count_d);

endmodule

// File: rtl/lru_frame_replacer.sv
// Recency-ordered frame list with one command per transfer.
// The input transfer loads the input stage register; the result register loads from it when the
// output advances. One command is taken per cycle while the output is not stalled.
// The compare over all slots and the shift of the list sit between the two registers.
// Reset empties the list and sets the capacity to sixteen; slot contents are not cleared.
module lru_frame_replacer import lfr_pkg::*; #(
  parameter int MaxEntries = MaxEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lfr_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfr_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CapBits-1:0] cfg_data_i
);

  logic               advance;
  logic               item_valid;
  lfr_in_t            item;
  logic               step;
  lfr_out_t           res;
  logic               out_valid_q, out_valid_d;
  lfr_out_t           out_data_q;
  logic [CapBits-1:0] cap_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign step    = item_valid && advance;

  lfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  lfr_list #(
    .MaxEntries (MaxEntries)
  ) u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .capacity_i (cap_q),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = item_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cap_q       <= CapacityReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: test/tb_top.sv
module tb_top;
  import lfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases = 8;
  localparam int PhaseItems = 205;
  localparam int HoldCycles = 120;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lfr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lfr_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CapBits-1:0] cfg_data_i = '0;

  lfr_in_t cmd_backlog[$];
  lfr_out_t expected_results[$];

  logic [FrameIdBits-1:0] lru_order[MaxEntriesDef];
  int lru_held = 0;
  logic [CapBits-1:0] cap_setting = CapacityReset;

  logic [FrameIdBits-1:0] id_pool[64];
  int tx_idle_pct = 32;
  int rx_stall_pct = 47;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  lru_frame_replacer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void drop_entry(int slot);
    for (int i = slot; i + 1 < lru_held; i++) begin
      lru_order[i] = lru_order[i + 1];
    end
    lru_held--;
  endfunction

  function automatic lfr_out_t predict_replacement(lfr_in_t item);
    lfr_out_t res;
    int hit;
    int eff_cap;
    res = '0;
    hit = -1;
    for (int i = 0; i < lru_held; i++) begin
      if (hit < 0 && lru_order[i] == item.frame_no) begin
        hit = i;
      end
    end
    eff_cap = (cap_setting == 0) ? 1 : int'(cap_setting);
    if (eff_cap > MaxEntriesDef) begin
      eff_cap = MaxEntriesDef;
    end
    case (item.command)
      CmdSelect: begin
        if (lru_held > 0) begin
          res.victim_valid = 1'b1;
          res.victim_id = lru_order[0];
          drop_entry(0);
        end
      end
      CmdTouch, CmdInsert: begin
        if (hit >= 0) begin
          drop_entry(hit);
          lru_order[lru_held] = item.frame_no;
          lru_held++;
        end else if (item.command == CmdInsert) begin
          if (lru_held >= eff_cap) begin
            drop_entry(0);
          end
          if (lru_held < MaxEntriesDef) begin
            lru_order[lru_held] = item.frame_no;
            lru_held++;
          end
        end
      end
      CmdRemove: begin
        if (hit >= 0) begin
          drop_entry(hit);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OccBits'(lru_held);
    return res;
  endfunction

  function automatic lfr_in_t random_command(int pool_n);
    lfr_in_t item;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      item.command = CmdInsert;
    end else if (pick < 65) begin
      item.command = CmdTouch;
    end else if (pick < 82) begin
      item.command = CmdRemove;
    end else begin
      item.command = CmdSelect;
    end
    pick = $urandom_range(99);
    if (pick < 86) begin
      item.frame_no = id_pool[$urandom_range(pool_n - 1)];
    end else if (pick < 96) begin
      item.frame_no = FrameIdBits'($urandom);
    end else begin
      item.frame_no = pick[0] ? '1 : '0;
    end
    return item;
  endfunction

  function automatic lfr_in_t make_command(lfr_cmd_e cmd, logic [FrameIdBits-1:0] id);
    lfr_in_t item;
    item.command = cmd;
    item.frame_no = id;
    return item;
  endfunction

  // Sender: the prediction is made at the edge at which the transfer takes place.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_replacement(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= cmd_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a long hold-off, when requested, keeps the output stalled so that the
  // block fills up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lfr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer: valid=%0b id=%0h occ=%0d", $time,
                 out_data_o.victim_valid, out_data_o.victim_id, out_data_o.occupancy);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.victim_valid !== want.victim_valid ||
            out_data_o.victim_id !== want.victim_id ||
            out_data_o.occupancy !== want.occupancy) begin
          $display("%0t: expected valid=%0b id=%0h occ=%0d, got valid=%0b id=%0h occ=%0d",
                   $time, want.victim_valid, want.victim_id, want.occupancy,
                   out_data_o.victim_valid, out_data_o.victim_id, out_data_o.occupancy);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (cmd_backlog.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_setting = value;
  endtask

  initial begin
    int phase_cap[NumPhases];
    int phase_pool[NumPhases];
    phase_cap = '{16, 5, 0, 31, 1, 16, 2, 17};
    phase_pool = '{40, 12, 6, 30, 8, 24, 20, 64};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cmd_backlog.push_back(make_command(CmdSelect, 8'hff));
    cmd_backlog.push_back(make_command(CmdTouch, 8'h12));
    cmd_backlog.push_back(make_command(CmdRemove, 8'h12));
    cmd_backlog.push_back(make_command(CmdInsert, 8'h00));
    cmd_backlog.push_back(make_command(CmdInsert, 8'hff));
    cmd_backlog.push_back(make_command(CmdInsert, 8'h5a));
    cmd_backlog.push_back(make_command(CmdInsert, 8'ha5));
    cmd_backlog.push_back(make_command(CmdInsert, 8'h00));
    cmd_backlog.push_back(make_command(CmdTouch, 8'hff));
    cmd_backlog.push_back(make_command(CmdSelect, 8'h00));
    cmd_backlog.push_back(make_command(CmdRemove, 8'ha5));
    cmd_backlog.push_back(make_command(CmdTouch, 8'h33));
    cmd_backlog.push_back(make_command(CmdSelect, 8'h00));
    cmd_backlog.push_back(make_command(CmdSelect, 8'h00));
    cmd_backlog.push_back(make_command(CmdSelect, 8'h00));
    for (int i = 0; i < 17; i++) begin
      cmd_backlog.push_back(make_command(CmdInsert, FrameIdBits'(8'h80 + i)));
    end
    cmd_backlog.push_back(make_command(CmdInsert, 8'h81));
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 3) begin
        tx_idle_pct = 32;
        rx_stall_pct = 47;
      end else if (p < 6) begin
        tx_idle_pct = 47;
        rx_stall_pct = 32;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      write_capacity(CapBits'(phase_cap[p]));
      for (int i = 0; i < 64; i++) begin
        id_pool[i] = FrameIdBits'($urandom);
      end
      if (p == 1 || p == 6) begin
        hold_req <= hold_req + 1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        cmd_backlog.push_back(random_command(phase_pool[p]));
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: lru_frame_replacer.f
rtl/lfr_pkg.sv
rtl/lfr_in_stage.sv
rtl/lfr_list.sv
rtl/lru_frame_replacer.sv
test/tb_top.sv
